// File: rtl/gtsd_pkg.sv
// Package for the gravity, tilt and shake detector: constants and shared types.
// Used by every module under rtl/.
`default_nettype none
package gtsd_pkg;
  localparam int unsigned CoefW = 16;
  localparam int unsigned LevelW = 17;
  localparam int unsigned OutTiltW = 16;
  localparam int unsigned AccW = 48;
  localparam int unsigned SqW = 64;

  localparam logic [CoefW-1:0] GravKeepRst = 16'd58982;
  localparam logic [CoefW-1:0] EnergyKeepRst = 16'd55706;
  localparam logic [LevelW-1:0] ShakeThrRst = 17'd1536;
  localparam logic [LevelW-1:0] MinGravRst = 17'd512;
  localparam logic signed [31:0] GzRst = 32'sd1285816;
  localparam logic [LevelW-1:0] MagMax = 17'h1FFFF;

  typedef enum logic [1:0] {
    REG_GRAV_KEEP = 2'd0,
    REG_ENERGY_KEEP = 2'd1,
    REG_SHAKE_THR = 2'd2,
    REG_MIN_GRAV = 2'd3
  } reg_idx_t;

  // Serial unit handshake: start pulse in, done pulse out.
  typedef struct packed {
    logic start;
    logic done;
  } unit_ctl_t;
endpackage
`default_nettype wire

// File: rtl/gtsd_sqrt.sv
// Bit-serial integer square root, two radicand bits per cycle.
// Depends on gtsd_pkg.
`default_nettype none
module gtsd_sqrt (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [gtsd_pkg::SqW-1:0] radicand,
  output logic                        done,
  output logic [gtsd_pkg::SqW/2-1:0]  root
);
  import gtsd_pkg::*;
  localparam int unsigned CntW = $clog2(SqW/2 + 1);

  logic [SqW-1:0] rad_r, rad_nxt;
  logic [SqW/2+1:0] rem_r, rem_nxt;
  logic [SqW/2-1:0] root_r, root_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [SqW/2+1:0] trial, shifted;

  always_comb begin
    rad_nxt = rad_r;
    rem_nxt = rem_r;
    root_nxt = root_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted = {rem_r[SqW/2-1:0], rad_r[SqW-1 -: 2]};
    trial = {root_r, 2'b01};
    if (start) begin
      rad_nxt = radicand;
      rem_nxt = '0;
      root_nxt = '0;
      cnt_nxt = CntW'(SqW/2);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[SqW-3:0], 2'b00};
      if (shifted >= trial) begin
        rem_nxt = shifted - trial;
        root_nxt = {root_r[SqW/2-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        root_nxt = {root_r[SqW/2-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rad_r <= rad_nxt;
    rem_r <= rem_nxt;
    root_r <= root_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r;

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start) else $error("sqrt restarted while busy");
  a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("sqrt done while busy");
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> cnt_r == '0 || $past(start)) else $error("sqrt count stale");
endmodule
`default_nettype wire

// File: rtl/gtsd_div.sv
// Bit-serial restoring divider for tilt, one quotient bit per cycle, with saturation.
// Depends on gtsd_pkg.
`default_nettype none
module gtsd_div #(
  parameter int unsigned FRAC = 14
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic signed [31:0]              numer,
  input  wire logic [gtsd_pkg::SqW/2-1:0]      denom,
  output logic                                 done,
  output logic [gtsd_pkg::OutTiltW-1:0]        quot
);
  import gtsd_pkg::*;
  localparam int unsigned NW = 32 + FRAC;
  localparam int unsigned CntW = $clog2(NW + 1);

  logic [NW-1:0] num_r, num_nxt;
  logic [SqW/2:0] rem_r, rem_nxt;
  logic [SqW/2-1:0] den_r, den_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic neg_r, neg_nxt, busy_r, busy_nxt, done_r, done_nxt;
  logic [SqW/2:0] shifted;
  logic [31:0] mag;
  logic [NW-1:0] lim;
  logic [NW-1:0] qsat;
  logic [NW-1:0] qsign;

  always_comb begin
    num_nxt = num_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    neg_nxt = neg_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    mag = numer[31] ? 32'(-numer) : 32'(numer);
    shifted = {rem_r[SqW/2-1:0], num_r[NW-1]};
    if (start) begin
      num_nxt = {mag, FRAC'(0)};
      rem_nxt = '0;
      den_nxt = denom;
      neg_nxt = numer[31];
      cnt_nxt = CntW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // quotient bits shift into num_r as the dividend shifts out
      if (shifted >= {1'b0, den_r}) begin
        rem_nxt = shifted - {1'b0, den_r};
        num_nxt = {num_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        num_nxt = {num_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    lim = NW'(1) << FRAC;
    qsat = (num_r > lim) ? lim : num_r;
    qsign = neg_r ? NW'(-qsat) : qsat;
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quot = qsign[OutTiltW-1:0];

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start) else $error("divider restarted while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");
  a_den_stable: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && $past(busy_r) |-> $stable(den_r)) else $error("divisor moved");
endmodule
`default_nettype wire

// File: rtl/gtsd_mac.sv
// Serial multiply-accumulate: shift-add over the 17 coefficient bits per term.
// Computes k*a + (65536-k)*b, result registered. Depends on gtsd_pkg.
`default_nettype none
module gtsd_mac (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [gtsd_pkg::CoefW-1:0]   keep,
  input  wire logic signed [39:0]           old_val,
  input  wire logic signed [39:0]           new_val,
  output logic                              done,
  output logic signed [gtsd_pkg::AccW+8:0]  acc
);
  import gtsd_pkg::*;
  localparam int unsigned PW = AccW + 9;

  logic [CoefW:0] ka_r, ka_nxt, kb_r, kb_nxt;
  logic signed [PW-1:0] ma_r, ma_nxt, mb_r, mb_nxt, acc_r, acc_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    ka_nxt = ka_r;
    kb_nxt = kb_r;
    ma_nxt = ma_r;
    mb_nxt = mb_r;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      ka_nxt = {1'b0, keep};
      kb_nxt = 17'h10000 - {1'b0, keep};
      ma_nxt = PW'(old_val);
      mb_nxt = PW'(new_val);
      acc_nxt = '0;
      cnt_nxt = 5'd17;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = acc_r + (ka_r[0] ? ma_r : '0) + (kb_r[0] ? mb_r : '0);
      ka_nxt = ka_r >> 1;
      kb_nxt = kb_r >> 1;
      ma_nxt = ma_r <<< 1;
      mb_nxt = mb_r <<< 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    ka_r <= ka_nxt;
    kb_r <= kb_nxt;
    ma_r <= ma_nxt;
    mb_r <= mb_nxt;
    acc_r <= acc_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign acc = acc_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start) else $error("mac restarted while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("mac done while busy");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> cnt_r == 5'd17) else $error("mac count not loaded");
endmodule
`default_nettype wire

// File: rtl/gravity_tilt_shake_detector.sv
// Channel  Dir  Width  Fields
// in_      in   48     accel_x, accel_y, accel_z (tvalid/tready)
// out_     out  72     tilt_x, tilt_y, shake_magnitude, energy_level, shake_flag (tvalid/tready)
// cfg_     in   32     APB, four registers at 0x0..0xC
// One item at a time: an item is accepted only in idle, and the block returns to idle
// once the result is registered for output. The divisions are skipped when gravity is
// too short for tilt. Each item runs three 17-step gravity filter updates, the energy
// update, two 32-step square roots and, when tilt is computed, two 46-step divisions.
// Synchronous active-low reset returns gravity and energy to their start values.
// A finished result waits in the output register while the next item is processed;
// hold in the output state while that register is still full.
// Depends on gtsd_pkg, gtsd_mac, gtsd_sqrt and gtsd_div.
`default_nettype none
module gravity_tilt_shake_detector #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned TILT_FRAC_BITS = 14
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // accel_x, accel_y, accel_z from bit 0 up
  input  wire logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // tilt_x[15:0], tilt_y[31:16], shake_magnitude[48:32], energy_level[65:49], shake_flag[66]
  output logic [71:0]                       out_tdata,
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [3:0]                   cfg_paddr,
  input  wire logic [31:0]                  cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);
  import gtsd_pkg::*;
  localparam int unsigned SW = SAMPLE_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE, S_GRAV, S_GWAIT, S_DYN, S_SQDS, S_SQD, S_ENER, S_EWAIT, S_GSUM,
    S_SQGS, S_SQG, S_DIVXS, S_DIVX, S_DIVYS, S_DIVY, S_OUT
  } state_t;

  state_t state_r;
  logic [CoefW-1:0] gkeep_r, ekeep_r;
  logic [LevelW-1:0] thr_r, ming_r;
  logic signed [31:0] grav_r [3];
  logic [31:0] energy_r;
  logic signed [SW-1:0] acc_r [3];
  logic [1:0] axis_r;
  logic [SqW-1:0] sum_r;
  logic [LevelW-1:0] mag_r;
  logic [OutTiltW-1:0] tx_r, ty_r;
  logic out_valid_r;
  logic [71:0] out_data_r;
  logic [SqW/2-1:0] len_r;

  // filter, square-root and divider units
  logic mac_start, mac_done, sqrt_start, sqrt_done, div_start, div_done;
  logic signed [39:0] mac_old, mac_new;
  logic [CoefW-1:0] mac_keep;
  logic signed [AccW+8:0] mac_acc;
  logic signed [AccW+8:0] filt;
  logic [SqW/2-1:0] root;
  logic signed [31:0] div_num;
  logic [OutTiltW-1:0] quot;
  logic cfg_wr;
  logic signed [31:0] sample_q8;
  logic signed [31:0] gcur;
  logic signed [32:0] diff;
  logic signed [31:0] dyn;
  logic signed [31:0] gs;
  logic signed [31:0] sq_src;
  logic [31:0] sq_op;
  logic [SqW-1:0] sq;
  logic [SqW-1:0] lim2;
  logic [LevelW-1:0] mag_sat;
  logic [1:0] idx;

  gtsd_mac u_mac (.clk, .rst_n, .start(mac_start), .keep(mac_keep),
    .old_val(mac_old), .new_val(mac_new), .done(mac_done), .acc(mac_acc));
  gtsd_sqrt u_sqrt (.clk, .rst_n, .start(sqrt_start), .radicand(sum_r),
    .done(sqrt_done), .root(root));
  gtsd_div #(.FRAC(TILT_FRAC_BITS)) u_div (.clk, .rst_n, .start(div_start),
    .numer(div_num), .denom(len_r), .done(div_done), .quot(quot));

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx = cfg_paddr[3:2];

  always_comb begin
    unique case (reg_idx_t'(idx))
      REG_GRAV_KEEP: cfg_prdata = 32'(gkeep_r);
      REG_ENERGY_KEEP: cfg_prdata = 32'(ekeep_r);
      REG_SHAKE_THR: cfg_prdata = 32'(thr_r);
      REG_MIN_GRAV: cfg_prdata = 32'(ming_r);
      default: cfg_prdata = '0;
    endcase
  end

  always_comb begin
    sample_q8 = 32'(acc_r[axis_r]) <<< 8;
    gcur = grav_r[axis_r];
    filt = (mac_acc + 57'sd32768) >>> 16;
    diff = 33'(sample_q8) - 33'(gcur);
    dyn = 32'(diff >>> 4);
    gs = gcur >>> 4;
    // one squarer shared by the dynamic and the gravity sums
    sq_src = (state_r == S_GSUM) ? gs : dyn;
    sq_op = sq_src[31] ? 32'(-sq_src) : 32'(sq_src);
    sq = SqW'(sq_op) * SqW'(sq_op);
    lim2 = SqW'({ming_r, 4'b0}) * SqW'({ming_r, 4'b0});
    mag_sat = (root[SqW/2-1:4] > 28'(MagMax)) ? MagMax : root[4+LevelW-1:4];
    mac_start = (state_r == S_GRAV) || (state_r == S_ENER);
    sqrt_start = (state_r == S_SQDS) || (state_r == S_SQGS);
    div_start = (state_r == S_DIVXS) || (state_r == S_DIVYS);
    mac_keep = (state_r == S_ENER) ? ekeep_r : gkeep_r;
    mac_old = (state_r == S_ENER) ? 40'($signed({1'b0, energy_r})) : 40'(gcur);
    mac_new = (state_r == S_ENER) ? 40'($signed({1'b0, mag_r, 8'b0})) : 40'(sample_q8);
    div_num = (state_r == S_DIVXS) ? -(grav_r[1] >>> 4) : (grav_r[0] >>> 4);
  end

  // one clocked block for state, configuration, datapath registers and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      gkeep_r <= GravKeepRst;
      ekeep_r <= EnergyKeepRst;
      thr_r <= ShakeThrRst;
      ming_r <= MinGravRst;
      grav_r[0] <= '0;
      grav_r[1] <= '0;
      grav_r[2] <= GzRst;
      energy_r <= '0;
      out_valid_r <= 1'b0;
      axis_r <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (reg_idx_t'(idx))
          REG_GRAV_KEEP: gkeep_r <= cfg_pwdata[CoefW-1:0];
          REG_ENERGY_KEEP: ekeep_r <= cfg_pwdata[CoefW-1:0];
          REG_SHAKE_THR: thr_r <= cfg_pwdata[LevelW-1:0];
          REG_MIN_GRAV: ming_r <= cfg_pwdata[LevelW-1:0];
          default: ;
        endcase
      end
      if (state_r == S_OUT && (!out_valid_r || out_tready)) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_tvalid) begin
          acc_r[0] <= in_tdata[SW-1:0];
          acc_r[1] <= in_tdata[2*SW-1:SW];
          acc_r[2] <= in_tdata[3*SW-1:2*SW];
          axis_r <= '0;
          state_r <= S_GRAV;
        end
        S_GRAV: state_r <= S_GWAIT;
        S_GWAIT: if (mac_done) begin
          grav_r[axis_r] <= filt[31:0];
          if (axis_r == 2'd2) begin
            axis_r <= '0;
            sum_r <= '0;
            state_r <= S_DYN;
          end else begin
            axis_r <= axis_r + 1'b1;
            state_r <= S_GRAV;
          end
        end
        S_DYN: begin
          sum_r <= sum_r + sq;
          if (axis_r == 2'd2) state_r <= S_SQDS;
          else axis_r <= axis_r + 1'b1;
        end
        S_SQDS: state_r <= S_SQD;
        S_SQD: if (sqrt_done) begin
          mag_r <= mag_sat;
          state_r <= S_ENER;
        end
        S_ENER: state_r <= S_EWAIT;
        S_EWAIT: if (mac_done) begin
          energy_r <= filt[31:0];
          axis_r <= '0;
          sum_r <= '0;
          state_r <= S_GSUM;
        end
        S_GSUM: begin
          sum_r <= sum_r + sq;
          if (axis_r == 2'd2) state_r <= S_SQGS;
          else axis_r <= axis_r + 1'b1;
        end
        S_SQGS: state_r <= S_SQG;
        S_SQG: if (sqrt_done) begin
          len_r <= root;
          if (sum_r > lim2) begin
            state_r <= S_DIVXS;
          end else begin
            tx_r <= '0;
            ty_r <= '0;
            state_r <= S_OUT;
          end
        end
        S_DIVXS: state_r <= S_DIVX;
        S_DIVX: if (div_done) begin
          tx_r <= quot;
          state_r <= S_DIVYS;
        end
        S_DIVYS: state_r <= S_DIVY;
        S_DIVY: if (div_done) begin
          ty_r <= quot;
          state_r <= S_OUT;
        end
        S_OUT: if (!out_valid_r || out_tready) begin
          out_data_r <= {5'b0, (mag_r > thr_r), energy_r[8+LevelW-1:8], mag_r, ty_r, tx_r};
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(sqrt_start && div_start)) else $error("two units started");
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_GRAV) else $error("item not started");
endmodule
`default_nettype wire
